// File: rtl/xpf_pkg.sv
// Package for the XOR parity FEC recovery block: default sizes, field widths,
// command and status codes, APB register map. No dependencies.
package xpf_pkg;

   // default sizing
   localparam int DEF_DATA_PACKETS     = 4;
   localparam int DEF_GROUP_POSITIONS  = 5;
   localparam int DEF_MAX_PACKET_BYTES = 2048;
   localparam int DEF_GROUP_SLOTS      = 4;

   // request / response field widths
   localparam int CMD_W    = 2;
   localparam int SEQ_W    = 32;
   localparam int IDX_W    = 11;
   localparam int BYTE_W   = 8;
   localparam int TYPE_W   = 7;
   localparam int LOST_W   = 2;
   localparam int STATUS_W = 2;

   // commands
   localparam logic [CMD_W-1:0] CMD_DATA   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PARITY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // response status
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_HELD = 2'd2;

   // flag bit 7 of byte zero is stripped
   localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h7F;

   // APB map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FIRST_TYPE = 1'b0;
   localparam logic REG_LAST_TYPE  = 1'b1;

endpackage

// File: rtl/xpf_if.sv
// Request and response channel interfaces for the XOR parity FEC block.
// Depends on xpf_pkg for field widths.
interface xpf_req_if;
   import xpf_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [SEQ_W-1:0]  sequence_req;
   logic [IDX_W-1:0]  byte_index;
   logic [BYTE_W-1:0] byte_value;
   logic              last_byte;

   modport source (output valid, command, sequence_req, byte_index, byte_value, last_byte,
                   input ready);
   modport sink   (input valid, command, sequence_req, byte_index, byte_value, last_byte,
                   output ready);
endinterface

interface xpf_rsp_if;
   import xpf_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   read_byte;
   logic                recover_ready;
   logic [LOST_W-1:0]   lost_position;
   logic [SEQ_W-1:0]    recovered_sequence;
   logic [TYPE_W-1:0]   recovered_type;
   logic                bad_type;
   logic [STATUS_W-1:0] status;

   modport source (output valid, read_byte, recover_ready, lost_position, recovered_sequence,
                   recovered_type, bad_type, status, input ready);
   modport sink   (input valid, read_byte, recover_ready, lost_position, recovered_sequence,
                   recovered_type, bad_type, status, output ready);
endinterface

// File: rtl/xor_parity_fec_recovery_core.sv
// Top level of the XOR parity erasure FEC receiver: accumulator RAM, slot table,
// sequencer and APB registers. Depends on xpf_pkg and the channels in xpf_if.sv.
//
//   channel  | dir | handshake          | contents
//   ---------+-----+--------------------+----------------------------------------------
//   req_bus  | in  | valid/ready        | command, sequence_req, byte_index, value, last
//   rsp_bus  | out | valid/ready        | read byte, recovery report, status
//   APB      | in  | psel/penable/pready| first_valid_type @0x0, last_valid_type @0x4
//
// One request at a time through a state sequencer. The shared reciprocal divider
// (two passes) and the accumulator RAM read-modify-write set the time from accept
// to result. A request that evicts a slot first zeroes the slot's RAM region.
// Reset (synchronous) clears the sequencer, response valid and slot valid bits
// and sets the type range to first 0, last 127; RAM needs no clearing since a
// slot is zeroed when first taken. A stalled response holds in the output
// register while the next request is already taken in.
module xor_parity_fec_recovery_core #(
   parameter int DATA_PACKETS     = xpf_pkg::DEF_DATA_PACKETS,
   parameter int GROUP_POSITIONS  = xpf_pkg::DEF_GROUP_POSITIONS,
   parameter int MAX_PACKET_BYTES = xpf_pkg::DEF_MAX_PACKET_BYTES,
   parameter int GROUP_SLOTS      = xpf_pkg::DEF_GROUP_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   xpf_req_if.sink                        req_bus,
   xpf_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [xpf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [xpf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [xpf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import xpf_pkg::*;

   // sizing
   localparam int MASK_W     = DATA_PACKETS + 1;           // data positions plus parity
   localparam int POS_SPAN   = (GROUP_POSITIONS > MASK_W) ? GROUP_POSITIONS : MASK_W;
   localparam int POS_W      = $clog2(POS_SPAN);
   localparam int SLOT_W     = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
   localparam int OFS_W      = $clog2(MAX_PACKET_BYTES);
   localparam int ACC_DEPTH  = GROUP_SLOTS * MAX_PACKET_BYTES;
   localparam int ADDR_W     = $clog2(ACC_DEPTH);
   localparam int STEPS_RAW  = IDX_W - OFS_W + 1;
   localparam int IDX_STEPS  = (STEPS_RAW < 1) ? 1 : STEPS_RAW;
   localparam int DEN_W      = 8;
   localparam logic [32:0]      POS_RECIP  = 33'((65'd1 << 32) / GROUP_POSITIONS);
   localparam logic [32:0]      SLOT_RECIP = 33'((65'd1 << 32) / GROUP_SLOTS);
   localparam logic [OFS_W-1:0] CLR_LAST   = OFS_W'(MAX_PACKET_BYTES - 1);

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_DIV  = 13'b0000000000010,   // seq * 1/positions
      S_DIVF = 13'b0000000000100,   // correct -> group, position
      S_MOD  = 13'b0000000001000,   // group * 1/slots
      S_MODF = 13'b0000000010000,   // correct -> slot
      S_SRD  = 13'b0000000100000,   // slot table read
      S_DEC  = 13'b0000001000000,   // decide, accumulator read at byte
      S_CLR  = 13'b0000010000000,   // zero slot region
      S_ARD  = 13'b0000100000000,   // accumulator reread after clear, held read result
      S_XOR  = 13'b0001000000000,   // write back accumulated byte
      S_TRD  = 13'b0010000000000,   // read byte zero for type
      S_CHK  = 13'b0100000000000,   // recovery check, mask writeback
      S_FIN  = 13'b1000000000000    // hand result to output register
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  group;
      logic [MASK_W-1:0] mask;
   } slot_entry_type;

   state_type state_ff, state_in;

   // request capture
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [OFS_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] val_ff, val_in;
   logic              last_ff, last_in;
   logic [31:0]       idx_rem;

   // divider
   logic [64:0]       prod_ff, prod_in;
   logic [31:0]       mul_a;
   logic [32:0]       mul_m;
   logic [31:0]       div_num;
   logic [DEN_W-1:0]  div_den;
   logic [31:0]       q_est;
   logic [39:0]       qd;
   logic [31:0]       r_est;
   logic              r_over;
   logic [31:0]       q_fix;
   logic [31:0]       r_fix;

   logic [SEQ_W-1:0]  group_ff, group_in;
   logic [POS_W-1:0]  rem_ff, rem_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [OFS_W-1:0]  clr_cnt_ff, clr_cnt_in;

   // decode
   logic              held;
   logic [POS_W-1:0]  pos;
   logic [MASK_W-1:0] pos_bit;
   logic [POS_W-1:0]  lost_idx;
   logic              one_lost;
   logic              recoverable;
   logic              type_ok;
   logic [MASK_W-1:0] lost_bit;

   // result staging
   logic [BYTE_W-1:0]   res_byte_ff, res_byte_in;
   logic                res_rec_ff, res_rec_in;
   logic [LOST_W-1:0]   res_lost_ff, res_lost_in;
   logic [SEQ_W-1:0]    res_seq_ff, res_seq_in;
   logic [TYPE_W-1:0]   res_type_ff, res_type_in;
   logic                res_bad_ff, res_bad_in;
   logic [STATUS_W-1:0] res_stat_ff, res_stat_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic                rsp_rec_ff;
   logic [LOST_W-1:0]   rsp_lost_ff;
   logic [SEQ_W-1:0]    rsp_seq_ff;
   logic [TYPE_W-1:0]   rsp_type_ff;
   logic                rsp_bad_ff;
   logic [STATUS_W-1:0] rsp_stat_ff;
   logic                fin_load;

   // slot state
   logic [GROUP_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   slot_entry_type         slot_mem [GROUP_SLOTS];
   slot_entry_type         slot_rd_ff;
   logic                   slot_we;
   slot_entry_type         slot_wdata;

   // accumulator RAM
   logic [BYTE_W-1:0] acc_mem [ACC_DEPTH];
   logic [BYTE_W-1:0] acc_rd_ff;
   logic              acc_we;
   logic [ADDR_W-1:0] acc_waddr;
   logic [BYTE_W-1:0] acc_wdata;
   logic [ADDR_W-1:0] acc_raddr;

   // config
   logic [TYPE_W-1:0] first_type_ff, first_type_in;
   logic [TYPE_W-1:0] last_type_ff, last_type_in;
   logic              csr_write;

   //------------------------------------------------------------------
   // APB registers
   //------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      first_type_in = first_type_ff;
      last_type_in  = last_type_ff;
      if (csr_write) begin
         if (paddr[2] == REG_FIRST_TYPE) begin
            first_type_in = pwdata[TYPE_W-1:0];
         end else begin
            last_type_in = pwdata[TYPE_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_LAST_TYPE) ? CSR_DATA_W'(last_type_ff)
                                               : CSR_DATA_W'(first_type_ff);

   //------------------------------------------------------------------
   // Byte offset modulo packet size: binary restoring, quotient < 2^IDX_STEPS
   //------------------------------------------------------------------
   always_comb begin
      idx_rem = 32'(req_bus.byte_index);
      for (int k = IDX_STEPS - 1; k >= 0; k--) begin
         if (idx_rem >= (32'(MAX_PACKET_BYTES) << k)) begin
            idx_rem = idx_rem - (32'(MAX_PACKET_BYTES) << k);
         end
      end
   end

   //------------------------------------------------------------------
   // Shared reciprocal divider: q_est is exact or one low, one fixup step
   //------------------------------------------------------------------
   assign mul_a   = (state_ff == S_MOD) ? group_ff : seq_ff;
   assign mul_m   = (state_ff == S_MOD) ? SLOT_RECIP : POS_RECIP;
   assign prod_in = {33'b0, mul_a} * {32'b0, mul_m};

   assign div_num = (state_ff == S_MODF) ? group_ff : seq_ff;
   assign div_den = (state_ff == S_MODF) ? DEN_W'(GROUP_SLOTS) : DEN_W'(GROUP_POSITIONS);
   assign q_est   = prod_ff[63:32];
   assign qd      = 40'(q_est) * 40'(div_den);
   assign r_est   = div_num - qd[31:0];
   assign r_over  = (r_est >= 32'(div_den));
   assign q_fix   = r_over ? (q_est + 32'd1) : q_est;
   assign r_fix   = r_over ? (r_est - 32'(div_den)) : r_est;

   //------------------------------------------------------------------
   // Decode helpers
   //------------------------------------------------------------------
   assign held    = slot_valid_ff[slot_ff] && (slot_rd_ff.group == group_ff);
   assign pos     = (cmd_ff == CMD_PARITY) ? POS_W'(DATA_PACKETS) : rem_ff;
   assign pos_bit = MASK_W'(1) << pos;

   always_comb begin
      lost_idx = '0;
      for (int i = 0; i < DATA_PACKETS; i++) begin
         if (!mask_ff[i]) begin
            lost_idx = POS_W'(i);
         end
      end
   end

   assign one_lost    = ($countones(~mask_ff[DATA_PACKETS-1:0]) == 1);
   assign recoverable = one_lost && mask_ff[DATA_PACKETS];
   assign type_ok     = (acc_rd_ff[TYPE_W-1:0] >= first_type_ff) &&
                        (acc_rd_ff[TYPE_W-1:0] <= last_type_ff);
   assign lost_bit    = MASK_W'(1) << lost_idx;

   assign fin_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_bus.ready);

   //------------------------------------------------------------------
   // Sequencer
   //------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      seq_in        = seq_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      last_in       = last_ff;
      group_in      = group_ff;
      rem_in        = rem_ff;
      slot_in       = slot_ff;
      base_in       = base_ff;
      mask_in       = mask_ff;
      clr_cnt_in    = clr_cnt_ff;
      slot_valid_in = slot_valid_ff;
      res_byte_in   = res_byte_ff;
      res_rec_in    = res_rec_ff;
      res_lost_in   = res_lost_ff;
      res_seq_in    = res_seq_ff;
      res_type_in   = res_type_ff;
      res_bad_in    = res_bad_ff;
      res_stat_in   = res_stat_ff;
      slot_we       = 1'b0;
      slot_wdata    = '{group: group_ff, mask: '0};
      acc_we        = 1'b0;
      acc_waddr     = base_ff + ADDR_W'(idx_ff);
      acc_wdata     = acc_rd_ff ^ val_ff;
      acc_raddr     = (state_ff == S_TRD) ? base_ff : (base_ff + ADDR_W'(idx_ff));

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in  = req_bus.command;
               seq_in  = req_bus.sequence_req;
               idx_in  = idx_rem[OFS_W-1:0];
               last_in = req_bus.last_byte;
               // parity byte zero carries the flag bit cleared
               if ((req_bus.command == CMD_PARITY) && (idx_rem == 32'd0)) begin
                  val_in = req_bus.byte_value & TYPE_MASK;
               end else begin
                  val_in = req_bus.byte_value;
               end
               res_byte_in = '0;
               res_rec_in  = 1'b0;
               res_lost_in = '0;
               res_seq_in  = '0;
               res_type_in = '0;
               res_bad_in  = 1'b0;
               res_stat_in = STAT_OK;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            state_in = S_DIVF;
         end
         S_DIVF: begin
            group_in = q_fix;
            rem_in   = r_fix[POS_W-1:0];
            state_in = S_MOD;
         end
         S_MOD: begin
            state_in = S_MODF;
         end
         S_MODF: begin
            slot_in  = r_fix[SLOT_W-1:0];
            state_in = S_SRD;
         end
         S_SRD: begin
            base_in  = ADDR_W'(ADDR_W'(slot_ff) * ADDR_W'(MAX_PACKET_BYTES));
            state_in = S_DEC;
         end
         S_DEC: begin
            priority if (cmd_ff == CMD_UNUSED) begin
               state_in = S_FIN;
            end else if (cmd_ff == CMD_READ) begin
               if (!held) begin
                  res_stat_in = STAT_NOT_HELD;
                  state_in    = S_FIN;
               end else begin
                  // accumulator byte arrives next cycle, taken in S_ARD below
                  state_in = S_ARD;
               end
            end else if ((cmd_ff == CMD_DATA) && (rem_ff >= POS_W'(DATA_PACKETS))) begin
               // data sequence on the parity position
               res_stat_in = STAT_DROPPED;
               state_in    = S_FIN;
            end else if (!held) begin
               // evict: take the slot over and zero its region
               slot_we                = 1'b1;
               slot_wdata             = '{group: group_ff, mask: '0};
               slot_valid_in[slot_ff] = 1'b1;
               mask_in                = '0;
               clr_cnt_in             = '0;
               state_in               = S_CLR;
            end else if ((slot_rd_ff.mask & pos_bit) != '0) begin
               res_stat_in = STAT_DROPPED;
               state_in    = S_FIN;
            end else begin
               mask_in  = slot_rd_ff.mask;
               state_in = S_XOR;
            end
         end
         S_CLR: begin
            acc_we     = 1'b1;
            acc_waddr  = base_ff + ADDR_W'(clr_cnt_ff);
            acc_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + OFS_W'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = S_ARD;
            end
         end
         S_ARD: begin
            if (cmd_ff == CMD_READ) begin
               // read data for byte of a held group is in acc_rd_ff now
               if (idx_ff == '0) begin
                  res_byte_in = acc_rd_ff & TYPE_MASK;
               end else begin
                  res_byte_in = acc_rd_ff;
               end
               state_in = S_FIN;
            end else begin
               state_in = S_XOR;
            end
         end
         S_XOR: begin
            acc_we = 1'b1;
            if (last_ff) begin
               mask_in  = mask_ff | pos_bit;
               state_in = S_TRD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_TRD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            slot_we    = 1'b1;
            slot_wdata = '{group: group_ff, mask: mask_ff};
            if (recoverable) begin
               res_lost_in = lost_idx[LOST_W-1:0];
               res_seq_in  = seq_ff - SEQ_W'(rem_ff) + SEQ_W'(lost_idx);
               res_type_in = acc_rd_ff[TYPE_W-1:0];
               if (type_ok) begin
                  res_rec_in = 1'b1;
                  slot_wdata = '{group: group_ff, mask: mask_ff | lost_bit};
               end else begin
                  res_bad_in = 1'b1;
               end
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (fin_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // read path timing: DEC presents the byte address, so a held read goes
   // DEC -> ARD with the byte already registered; ARD also serves the reread
   // after a clear, where the address is presented again in CLR's last cycle.

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   //------------------------------------------------------------------
   // Registers
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         first_type_ff <= '0;
         last_type_ff  <= '1;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_valid_ff <= slot_valid_in;
         first_type_ff <= first_type_in;
         last_type_ff  <= last_type_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      seq_ff      <= seq_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      group_ff    <= group_in;
      rem_ff      <= rem_in;
      slot_ff     <= slot_in;
      base_ff     <= base_in;
      mask_ff     <= mask_in;
      clr_cnt_ff  <= clr_cnt_in;
      res_byte_ff <= res_byte_in;
      res_rec_ff  <= res_rec_in;
      res_lost_ff <= res_lost_in;
      res_seq_ff  <= res_seq_in;
      res_type_ff <= res_type_in;
      res_bad_ff  <= res_bad_in;
      res_stat_ff <= res_stat_in;
      if (fin_load) begin
         rsp_byte_ff <= res_byte_ff;
         rsp_rec_ff  <= res_rec_ff;
         rsp_lost_ff <= res_lost_ff;
         rsp_seq_ff  <= res_seq_ff;
         rsp_type_ff <= res_type_ff;
         rsp_bad_ff  <= res_bad_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   // slot table: group tag and received mask, one port each way
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_ff] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[slot_ff];
   end

   // accumulator RAM, read data registered
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.read_byte          = rsp_byte_ff;
   assign rsp_bus.recover_ready      = rsp_rec_ff;
   assign rsp_bus.lost_position      = rsp_lost_ff;
   assign rsp_bus.recovered_sequence = rsp_seq_ff;
   assign rsp_bus.recovered_type     = rsp_type_ff;
   assign rsp_bus.bad_type           = rsp_bad_ff;
   assign rsp_bus.status             = rsp_stat_ff;

`ifndef ASSERT_OFF
   // an accepted request always starts the divider pass
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == S_DIV))
      else $error("accepted request did not enter divider");

   // zeroing only runs on a slot already taken over
   a_clear_owned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> slot_valid_ff[slot_ff])
      else $error("slot clear on a slot not marked valid");

   // a result waits while the previous one is still stalled
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && rsp_valid_ff && !rsp_bus.ready) |=> (state_ff == S_FIN))
      else $error("result handed over onto a stalled output");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for xor_parity_fec_recovery_core: directed plan, then random parity groups.
// Depends on rtl/xpf_pkg.sv, rtl/xpf_if.sv and the core; results checked in order.
module tb;
   import xpf_pkg::*;

   // sizes the core is built with (defaults)
   localparam int N_DATA    = DEF_DATA_PACKETS;
   localparam int N_POS     = DEF_GROUP_POSITIONS;
   localparam int PKT_BYTES = DEF_MAX_PACKET_BYTES;
   localparam int N_SLOTS   = DEF_GROUP_SLOTS;

   // highest group whose positions all fit in a 32-bit sequence
   localparam int unsigned MAX_GROUP = 32'hFFFF_FFFF / N_POS - 1;
   localparam int MAX_EP_BYTES  = 24;      // longest packet in the random groups
   localparam int RANDOM_ITEMS  = 850;
   localparam int PHASES        = 7;       // type-range settings, defaults first
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;     // long response stall, fills the core
   localparam int LIMIT_NS      = 10_000_000;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SEQ_W-1:0]  sequence_req;
      logic [IDX_W-1:0]  byte_index;
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } fec_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   read_byte;
      logic                recover_ready;
      logic [LOST_W-1:0]   lost_position;
      logic [SEQ_W-1:0]    recovered_sequence;
      logic [TYPE_W-1:0]   recovered_type;
      logic                bad_type;
      logic [STATUS_W-1:0] status;
   } fec_rsp_type;

   // one directed request: either its result is typed in, or the predictor supplies it
   typedef struct packed {
      fec_req_type req;
      logic        given;
      fec_rsp_type want;
   } plan_row_type;

   localparam logic BY_MODEL = 1'b0;
   localparam logic TYPED    = 1'b1;

   localparam fec_rsp_type R_ZERO     = '0;
   localparam fec_rsp_type R_DROPPED  = '{status: STAT_DROPPED, default: '0};
   localparam fec_rsp_type R_NOT_HELD = '{status: STAT_NOT_HELD, default: '0};

   // Directed plan. Group 0 is built from positions 0, 1, 3 and parity so that
   // position 2 comes back with type 0x46; parity header byte carries its flag.
   localparam plan_row_type DIRECTED_PLAN [24] = '{
      // nothing is held right after reset
      '{'{CMD_READ,   32'd0,         11'd0,    8'h00, 1'b0}, TYPED,    R_NOT_HELD},
      // unused command with every field at its top: all-zero result
      '{'{CMD_UNUSED, 32'hFFFF_FFFF, 11'd2047, 8'hFF, 1'b1}, TYPED,    R_ZERO},
      // data request whose sequence maps onto the parity position
      '{'{CMD_DATA,   32'd4,         11'd0,    8'h5A, 1'b1}, TYPED,    R_DROPPED},
      '{'{CMD_DATA,   32'd0,         11'd0,    8'h85, 1'b0}, BY_MODEL, R_ZERO},
      '{'{CMD_DATA,   32'd0,         11'd1,    8'h11, 1'b1}, BY_MODEL, R_ZERO},
      '{'{CMD_DATA,   32'd1,         11'd0,    8'h02, 1'b0}, BY_MODEL, R_ZERO},
      // read while the group is still open
      '{'{CMD_READ,   32'd1,         11'd0,    8'hFF, 1'b1}, BY_MODEL, R_ZERO},
      '{'{CMD_DATA,   32'd1,         11'd1,    8'h22, 1'b1}, BY_MODEL, R_ZERO},
      '{'{CMD_DATA,   32'd3,         11'd0,    8'h00, 1'b0}, BY_MODEL, R_ZERO},
      '{'{CMD_DATA,   32'd3,         11'd2047, 8'hFF, 1'b0}, BY_MODEL, R_ZERO},
      '{'{CMD_DATA,   32'd3,         11'd1,    8'h44, 1'b1}, BY_MODEL, R_ZERO},
      // parity tagged with a data sequence still lands on the parity position
      '{'{CMD_PARITY, 32'd2,         11'd0,    8'hC1, 1'b0}, BY_MODEL, R_ZERO},
      '{'{CMD_PARITY, 32'd2,         11'd1,    8'h77, 1'b1}, BY_MODEL, R_ZERO},
      // repeat of a received position, then of the recovered one
      '{'{CMD_DATA,   32'd0,         11'd0,    8'h33, 1'b1}, TYPED,    R_DROPPED},
      '{'{CMD_DATA,   32'd2,         11'd0,    8'h00, 1'b1}, TYPED,    R_DROPPED},
      '{'{CMD_READ,   32'd3,         11'd0,    8'h00, 1'b0}, BY_MODEL, R_ZERO},
      '{'{CMD_READ,   32'd0,         11'd2047, 8'h00, 1'b0}, BY_MODEL, R_ZERO},
      '{'{CMD_READ,   32'd5,         11'd0,    8'h00, 1'b0}, TYPED,    R_NOT_HELD},
      // top group: parity only, then the one data position that fits
      '{'{CMD_PARITY, 32'hFFFF_FFFF, 11'd2047, 8'h80, 1'b0}, BY_MODEL, R_ZERO},
      '{'{CMD_PARITY, 32'hFFFF_FFFF, 11'd0,    8'hFF, 1'b1}, BY_MODEL, R_ZERO},
      '{'{CMD_DATA,   32'hFFFF_FFFF, 11'd0,    8'h7F, 1'b1}, BY_MODEL, R_ZERO},
      // group 4 shares slot 0 with group 0: not held, then it evicts group 0
      '{'{CMD_READ,   32'd20,        11'd0,    8'h00, 1'b0}, TYPED,    R_NOT_HELD},
      '{'{CMD_DATA,   32'd20,        11'd0,    8'h01, 1'b1}, BY_MODEL, R_ZERO},
      '{'{CMD_READ,   32'd0,         11'd0,    8'h00, 1'b0}, TYPED,    R_NOT_HELD}
   };

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   xpf_req_if req_ch ();
   xpf_rsp_if rsp_ch ();

   xor_parity_fec_recovery_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the core: per-slot XOR bytes, received positions, group tags, type range
   logic [BYTE_W-1:0] acc_mem [N_SLOTS*PKT_BYTES];
   logic [N_POS-1:0]  seen_mask [N_SLOTS];
   logic [SEQ_W-1:0]  slot_grp [N_SLOTS];
   logic              slot_live [N_SLOTS];
   logic [TYPE_W-1:0] type_lo;
   logic [TYPE_W-1:0] type_hi;

   fec_rsp_type outcomes_due [$];   // results owed by the core, oldest first

   int mismatches = 0;
   int useful_items = 0;
   int n_recovered = 0;
   int n_bad_type = 0;
   int n_dropped = 0;
   int n_not_held = 0;
   int send_calm = 0;      // remaining requests sent back to back
   int recv_calm = 0;      // remaining results taken without stall
   logic hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

   // Wait count for the next request or result: mostly short, at times a calm
   // stretch of zero waits.
   function automatic int draw_wait(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 50);
         return 0;
      end
      case ($urandom_range(0, 3))
         0, 1: return 0;
         2: return $urandom_range(1, 3);
         default: return $urandom_range(4, 18);
      endcase
   endfunction

   // What the core answers to one accepted request; updates the shadow state.
   function automatic fec_rsp_type recovery_outcome(input fec_req_type r);
      fec_rsp_type       o;
      logic [SEQ_W-1:0]  grp;
      logic [BYTE_W-1:0] v;
      logic [TYPE_W-1:0] ty;
      logic              held;
      int                slot, base, pos, lost_n, lost;
      o = '0;
      grp = r.sequence_req / N_POS;
      slot = int'(grp % N_SLOTS);
      base = slot * PKT_BYTES;
      held = slot_live[slot] && slot_grp[slot] == grp;
      v = r.byte_value;
      lost_n = 0;
      lost = 0;
      if (r.command == CMD_UNUSED)
         return o;
      if (r.command == CMD_READ) begin
         if (!held) begin
            o.status = STAT_NOT_HELD;
         end else begin
            o.read_byte = acc_mem[base + r.byte_index];
            if (r.byte_index == 0)
               o.read_byte &= TYPE_MASK;
         end
         return o;
      end
      if (r.command == CMD_PARITY) begin
         pos = N_DATA;
         if (r.byte_index == 0)
            v &= TYPE_MASK;    // parity flag stripped before accumulation
      end else begin
         pos = int'(r.sequence_req % N_POS);
         if (pos >= N_DATA) begin
            o.status = STAT_DROPPED;
            return o;
         end
      end
      // a foreign group takes the slot over, clean
      if (!held) begin
         for (int i = 0; i < PKT_BYTES; i++)
            acc_mem[base + i] = '0;
         seen_mask[slot] = '0;
         slot_grp[slot] = grp;
         slot_live[slot] = 1'b1;
      end
      if (seen_mask[slot][pos]) begin
         o.status = STAT_DROPPED;
         return o;
      end
      acc_mem[base + r.byte_index] ^= v;
      if (!r.last_byte)
         return o;
      seen_mask[slot][pos] = 1'b1;
      for (int i = 0; i < N_DATA; i++) begin
         if (!seen_mask[slot][i]) begin
            lost_n++;
            lost = i;
         end
      end
      if (lost_n == 1 && seen_mask[slot][N_DATA]) begin
         ty = acc_mem[base][TYPE_W-1:0];
         o.lost_position = LOST_W'(lost);
         o.recovered_sequence = grp * N_POS + lost;
         o.recovered_type = ty;
         if (ty >= type_lo && ty <= type_hi) begin
            o.recover_ready = 1'b1;
            seen_mask[slot][lost] = 1'b1;
         end else begin
            o.bad_type = 1'b1;
         end
      end
      return o;
   endfunction

   function automatic string fmt_outcome(input fec_rsp_type o);
      return $sformatf("byte=%h rec=%b pos=%0d seq=%h type=%h bad=%b status=%0d",
                       o.read_byte, o.recover_ready, o.lost_position, o.recovered_sequence,
                       o.recovered_type, o.bad_type, o.status);
   endfunction

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Offer one request after a random gap and hold it until the core takes it.
   // valid stays high across back-to-back requests: only one assignment per step.
   task automatic send_request(input fec_req_type r, input logic given,
                               input fec_rsp_type want);
      int          gap;
      fec_rsp_type o;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= r.command;
      req_ch.sequence_req <= r.sequence_req;
      req_ch.byte_index   <= r.byte_index;
      req_ch.byte_value   <= r.byte_value;
      req_ch.last_byte    <= r.last_byte;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      o = recovery_outcome(r);
      outcomes_due.push_back(given ? want : o);
      if (r.command != CMD_UNUSED && o.status != STAT_DROPPED)
         useful_items++;
      n_recovered += int'(o.recover_ready);
      n_bad_type  += int'(o.bad_type);
      n_dropped   += int'(o.status == STAT_DROPPED);
      n_not_held  += int'(o.status == STAT_NOT_HELD);
   endtask

   // Stop offering and wait until every owed result is in, plus the core's tail.
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Program both type bounds, mirror them in the shadow, read both back.
   task automatic set_type_range(input logic [TYPE_W-1:0] lo, input logic [TYPE_W-1:0] hi);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, {REG_FIRST_TYPE, 2'b00}, CSR_DATA_W'(lo), rd);
      csr_access(1'b1, {REG_LAST_TYPE, 2'b00}, CSR_DATA_W'(hi), rd);
      type_lo = lo;
      type_hi = hi;
      csr_access(1'b0, {REG_FIRST_TYPE, 2'b00}, '0, rd);
      if (rd[TYPE_W-1:0] !== lo)
         log_mismatch($sformatf("first_valid_type exp %0d got %0d", lo, rd[TYPE_W-1:0]));
      csr_access(1'b0, {REG_LAST_TYPE, 2'b00}, '0, rd);
      if (rd[TYPE_W-1:0] !== hi)
         log_mismatch($sformatf("last_valid_type exp %0d got %0d", hi, rd[TYPE_W-1:0]));
   endtask

   // All bytes of one packet, index 0 upward; parity carries any sequence of its group.
   task automatic send_packet(input logic [SEQ_W-1:0] grp, input int pos, input int len,
                              input logic [MAX_EP_BYTES-1:0][BYTE_W-1:0] bytes);
      fec_req_type r;
      for (int k = 0; k < len; k++) begin
         r.command      = (pos == N_DATA) ? CMD_PARITY : CMD_DATA;
         r.sequence_req = grp * N_POS + ((pos == N_DATA) ? $urandom_range(0, N_POS - 1) : pos);
         r.byte_index   = IDX_W'(k);
         r.byte_value   = bytes[k];
         r.last_byte    = (k == len - 1);
         send_request(r, BY_MODEL, R_ZERO);
      end
   endtask

   // Stray request: any command, any index, mostly aimed at the current group.
   task automatic send_noise(input logic [SEQ_W-1:0] grp);
      fec_req_type r;
      r.command      = CMD_W'($urandom_range(CMD_DATA, CMD_UNUSED));
      r.sequence_req = ($urandom_range(0, 3) == 0) ? SEQ_W'($urandom)
                                                   : grp * N_POS + $urandom_range(0, N_POS - 1);
      r.byte_index   = IDX_W'($urandom_range(0, PKT_BYTES - 1));
      r.byte_value   = BYTE_W'($urandom);
      r.last_byte    = 1'($urandom_range(0, 1));
      send_request(r, BY_MODEL, R_ZERO);
   endtask

   // One parity group: random payloads, parity as their XOR (sometimes corrupted),
   // usually one data packet lost, packets in shuffled order, then a few reads back.
   task automatic run_group_episode();
      logic [SEQ_W-1:0] grp;
      logic [MAX_EP_BYTES-1:0][BYTE_W-1:0] payload [N_POS];
      logic sent [N_POS];
      logic done [N_POS];
      int order [$];
      int len, mode, a, b, k, j, tmp, pos, n_reads;
      fec_req_type r;
      grp = ($urandom_range(0, 6) == 0) ? SEQ_W'($urandom_range(0, 11))
                                        : SEQ_W'($urandom_range(0, MAX_GROUP));
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(7, MAX_EP_BYTES) : $urandom_range(1, 6);
      for (pos = 0; pos < N_POS; pos++) begin
         sent[pos] = 1'b1;
         done[pos] = 1'b0;
      end
      a = $urandom_range(0, N_DATA - 1);
      b = $urandom_range(0, N_DATA - 1);
      mode = $urandom_range(0, 9);
      if (mode < 9)
         sent[a] = 1'b0;        // single loss: the recoverable case
      if (mode == 7)
         sent[b] = 1'b0;        // second loss (may coincide with the first)
      if (mode == 8)
         sent[N_DATA] = 1'b0;   // parity lost too
      for (k = 0; k < MAX_EP_BYTES; k++) begin
         payload[N_DATA][k] = '0;
         for (pos = 0; pos < N_DATA; pos++) begin
            payload[pos][k] = BYTE_W'($urandom);
            payload[N_DATA][k] ^= payload[pos][k];
         end
      end
      payload[N_DATA][0][BYTE_W-1] = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0)
         payload[N_DATA][$urandom_range(0, len - 1)] = BYTE_W'($urandom);
      for (pos = 0; pos < N_POS; pos++)
         if (sent[pos])
            order.push_back(pos);
      for (k = order.size() - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) begin
         if ($urandom_range(0, 11) == 0)
            send_noise(grp);
         // resend of a finished packet: every byte dropped
         j = $urandom_range(0, N_POS - 1);
         if (done[j] && $urandom_range(0, 7) == 0)
            send_packet(grp, j, len, payload[j]);
         send_packet(grp, order[i], len, payload[order[i]]);
         done[order[i]] = 1'b1;
      end
      n_reads = $urandom_range(1, 3);
      for (k = 0; k < n_reads; k++) begin
         r.command      = CMD_READ;
         r.sequence_req = grp * N_POS + $urandom_range(0, N_POS - 1);
         r.byte_index   = IDX_W'($urandom_range(0, len));
         r.byte_value   = BYTE_W'($urandom);
         r.last_byte    = 1'($urandom_range(0, 1));
         send_request(r, BY_MODEL, R_ZERO);
      end
      // now and then the sender waits for the core to drain completely
      if ($urandom_range(0, 11) == 0)
         quiesce();
   endtask

   // Result side: random stall per result, one long hold when asked, in-order check.
   initial begin : result_side
      int          stall;
      fec_rsp_type got;
      fec_rsp_type want;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_wait(recv_calm);
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = '{rsp_ch.read_byte, rsp_ch.recover_ready, rsp_ch.lost_position,
                 rsp_ch.recovered_sequence, rsp_ch.recovered_type, rsp_ch.bad_type,
                 rsp_ch.status};
         if (outcomes_due.size() == 0) begin
            log_mismatch({"result with no request owed: ", fmt_outcome(got)});
         end else begin
            want = outcomes_due.pop_front();
            if (got !== want)
               log_mismatch({"exp ", fmt_outcome(want), " | got ", fmt_outcome(got)});
         end
      end
   end

   initial begin : request_side
      int base_items;
      logic [TYPE_W-1:0] lo;
      logic [TYPE_W-1:0] hi;
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.command       <= CMD_DATA;
      req_ch.sequence_req  <= '0;
      req_ch.byte_index    <= '0;
      req_ch.byte_value    <= '0;
      req_ch.last_byte     <= 1'b0;
      // shadow starts from the reset state
      foreach (acc_mem[i])
         acc_mem[i] = '0;
      foreach (seen_mask[i]) begin
         seen_mask[i] = '0;
         slot_grp[i]  = '0;
         slot_live[i] = 1'b0;
      end
      type_lo = '0;
      type_hi = 7'd127;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan under the reset type range
      foreach (DIRECTED_PLAN[i])
         send_request(DIRECTED_PLAN[i].req, DIRECTED_PLAN[i].given, DIRECTED_PLAN[i].want);

      // random groups, one share per type-range setting; registers change only idle
      base_items = useful_items;
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            quiesce();
            case (p)
               1: begin lo = 7'd0;   hi = 7'd0;   end
               2: begin lo = 7'd127; hi = 7'd127; end
               3: begin lo = 7'd90;  hi = 7'd20;  end   // inverted: nothing valid
               4: begin lo = 7'd0;   hi = 7'd127; end
               5: begin
                  lo = TYPE_W'($urandom_range(0, 127));
                  hi = TYPE_W'($urandom_range(lo, 127));
               end
               default: begin lo = 7'd32; hi = 7'd95; end
            endcase
            set_type_range(lo, hi);
         end
         // long response stall while requests keep coming back to back
         if (p == 2 || p == 5) begin
            hold_request = 1'b1;
            send_calm = 60;
         end
         while (useful_items < base_items + (p + 1) * RANDOM_ITEMS / PHASES)
            run_group_episode();
      end
      quiesce();

      $display("Covered %0d effective requests over %0d type-range settings incl. inverted.",
               useful_items, PHASES);
      $display("Recoveries %0d, out-of-range types %0d, drops %0d, reads of absent groups %0d.",
               n_recovered, n_bad_type, n_dropped, n_not_held);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
